### sv/timeslice_priority_scheduler_assert.svh
// Assertion macros used by the scheduler sequencer.
`ifndef TIMESLICE_PRIORITY_SCHEDULER_ASSERT_SVH
`define TIMESLICE_PRIORITY_SCHEDULER_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define TPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define TPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

### sv/tps_pkg.sv
// Shared types and constants of the timeslice priority scheduler.
`timescale 1ns / 1ps

package tps_pkg;

    localparam int CNT_W  = 9;
    localparam int PRI_W  = 8;
    localparam int TASK_W = 4;

    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [PRI_W-1:0] pri_t;

    // Command broadcast to every cell of the task chain
    typedef enum logic [1:0] {
        OP_NONE,
        OP_LOAD,
        OP_TICK,
        OP_REFILL
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        cnt_t     cnt;
        pri_t     pri;
        logic     runnable;
        logic     present;
    } cell_cmd_t;

    // Search wavefront handed from cell to cell
    typedef struct packed {
        cnt_t best_cnt;
        pri_t best_pri;
        cnt_t cur_cnt;
        pri_t cur_pri;
    } wave_t;

endpackage

### sv/tps_cell.sv
// One task table entry with its stage of the search wavefront.
`timescale 1ns / 1ps

module tps_cell
    import tps_pkg::*;
#(
    parameter int NUM_TASKS = 16,
    parameter int CELL_IDX  = 0,
    localparam int IDX_W    = $clog2(NUM_TASKS)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_cmd_t        cmd,
    input  logic [IDX_W-1:0] cmd_idx,
    input  logic [IDX_W-1:0] cur_idx,
    input  logic             go_in,
    input  wave_t            wave_in,
    input  logic [IDX_W-1:0] wave_in_idx,
    output logic             go_out,
    output wave_t            wave_out,
    output logic [IDX_W-1:0] wave_out_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
    localparam bit IS_IDLE_TASK = (CELL_IDX == 0);

    cnt_t cnt_reg, cnt_next;
    pri_t pri_reg, pri_next;
    logic run_reg, run_next;
    logic pres_reg, pres_next;

    logic             go_reg;
    wave_t            wave_reg, wave_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic is_cur;
    logic take;

    assign is_cur = (cur_idx == MY_IDX);

    // Update the entry on load, tick and refill commands
    always_comb
    begin
        cnt_next  = cnt_reg;
        pri_next  = pri_reg;
        run_next  = run_reg;
        pres_next = pres_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                if (cmd_idx == MY_IDX)
                begin
                    cnt_next  = cmd.cnt;
                    pri_next  = cmd.pri;
                    run_next  = cmd.runnable;
                    pres_next = cmd.present;
                end
            end
            OP_TICK:
            begin
                if (!IS_IDLE_TASK && is_cur)
                begin
                    if (cnt_reg <= cnt_t'(1))
                        cnt_next = '0;
                    else
                        cnt_next = cnt_reg - cnt_t'(1);
                end
            end
            OP_REFILL:
            begin
                if (!IS_IDLE_TASK && pres_reg)
                    cnt_next = {1'b0, cnt_reg[CNT_W-1:1]} + {1'b0, pri_reg};
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            pri_reg  <= '0;
            run_reg  <= 1'b0;
            pres_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            pri_reg  <= pri_next;
            run_reg  <= run_next;
            pres_reg <= pres_next;
        end
    end

    // Replace the candidate on a strictly larger counter; capture the running entry
    assign take = !IS_IDLE_TASK && pres_reg && run_reg && (cnt_reg > wave_in.best_cnt);

    always_comb
    begin
        wave_next = wave_in;
        idx_next  = wave_in_idx;
        if (take)
        begin
            wave_next.best_cnt = cnt_reg;
            wave_next.best_pri = pri_reg;
            idx_next           = MY_IDX;
        end
        if (is_cur)
        begin
            wave_next.cur_cnt = cnt_reg;
            wave_next.cur_pri = pri_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            go_reg <= 1'b0;
        else
            go_reg <= go_in;
    end

    // Advance the wavefront payload to the neighbor
    always_ff @(posedge clk)
    begin
        if (go_in)
        begin
            wave_reg <= wave_next;
            idx_reg  <= idx_next;
        end
    end

    assign go_out       = go_reg;
    assign wave_out     = wave_reg;
    assign wave_out_idx = idx_reg;

endmodule

### sv/tps_ctrl.sv
// Sequencer: item intake, chain commands, scan decisions and result register.
`timescale 1ns / 1ps
`include "timeslice_priority_scheduler_assert.svh"

module tps_ctrl
    import tps_pkg::*;
#(
    parameter int NUM_TASKS = 16,
    localparam int IDX_W    = $clog2(NUM_TASKS)
)
(
    input  logic              clk,
    input  logic              rst_n,
    // item channel
    input  logic              item_valid,
    output logic              item_stall,
    input  logic              mode,
    input  logic [TASK_W-1:0] task_index,
    input  cnt_t              load_counter,
    input  pri_t              load_priority,
    input  logic              load_runnable,
    input  logic              load_present,
    // chain side
    output cell_cmd_t         cmd,
    output logic [IDX_W-1:0]  cmd_idx,
    output logic [IDX_W-1:0]  cur_idx,
    output logic              head_go,
    output wave_t             head_wave,
    output logic [IDX_W-1:0]  head_idx,
    input  logic              tail_go,
    input  wave_t             tail_wave,
    input  logic [IDX_W-1:0]  tail_idx,
    // result channel
    output logic              result_valid,
    input  logic              result_stall,
    output logic [TASK_W-1:0] next_task,
    output logic              switched,
    output logic              refilled,
    output logic              none_ready,
    output cnt_t              next_counter,
    output pri_t              next_priority
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN1 = 4'b0010,
        S_SCAN2 = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic             launch_reg, launch_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic             tick_reg, tick_next;

    logic [IDX_W-1:0] res_task_reg, res_task_next;
    logic             res_sw_reg, res_sw_next;
    logic             res_rf_reg, res_rf_next;
    logic             res_nr_reg, res_nr_next;
    cnt_t             res_cnt_reg, res_cnt_next;
    pri_t             res_pri_reg, res_pri_next;

    logic              out_valid_reg;
    logic [TASK_W-1:0] out_task_reg;
    logic              out_sw_reg, out_rf_reg, out_nr_reg;
    cnt_t              out_cnt_reg;
    pri_t              out_pri_reg;

    logic        accept;
    logic [31:0] index_wide;
    logic        load_ok;
    logic        found;
    logic        resched;
    logic        need_refill;
    logic        out_free;

    assign accept     = item_valid && (state_reg == S_IDLE);
    assign item_stall = (state_reg != S_IDLE);
    assign index_wide = 32'(task_index);
    assign load_ok    = (index_wide < 32'(NUM_TASKS));

    // The second scan only runs for a tick that reschedules, whatever the refill left
    assign found       = (tail_wave.best_cnt != '0);
    assign resched     = (state_reg == S_SCAN2) || (cur_reg == '0) ||
                         (tail_wave.cur_cnt == '0);
    assign need_refill = tick_reg && resched && !found;
    assign out_free    = !out_valid_reg || !result_stall;

    // Drive the chain: commands, running index and wavefront head
    always_comb
    begin
        cmd.op       = OP_NONE;
        cmd.cnt      = load_counter;
        cmd.pri      = load_priority;
        cmd.runnable = load_runnable;
        cmd.present  = load_present;
        if (accept)
        begin
            if (mode)
                cmd.op = load_ok ? OP_LOAD : OP_NONE;
            else
                cmd.op = OP_TICK;
        end
        else if ((state_reg == S_SCAN1) && tail_go && need_refill)
        begin
            cmd.op = OP_REFILL;
        end
    end

    assign cmd_idx   = index_wide[IDX_W-1:0];
    assign cur_idx   = cur_reg;
    assign head_go   = launch_reg;
    assign head_wave = '0;
    assign head_idx  = '0;

    // Sequence the scans and settle the result
    always_comb
    begin
        state_next    = state_reg;
        launch_next   = 1'b0;
        cur_next      = cur_reg;
        tick_next     = tick_reg;
        res_task_next = res_task_reg;
        res_sw_next   = res_sw_reg;
        res_rf_next   = res_rf_reg;
        res_nr_next   = res_nr_reg;
        res_cnt_next  = res_cnt_reg;
        res_pri_next  = res_pri_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    tick_next   = !mode;
                    launch_next = 1'b1;
                    state_next  = S_SCAN1;
                end
            end
            S_SCAN1, S_SCAN2:
            begin
                if (tail_go)
                begin
                    // keep the running task unless a new pick is taken below
                    res_task_next = cur_reg;
                    res_sw_next   = 1'b0;
                    res_rf_next   = (state_reg == S_SCAN2);
                    res_nr_next   = 1'b0;
                    res_cnt_next  = tail_wave.cur_cnt;
                    res_pri_next  = tail_wave.cur_pri;
                    state_next    = S_DONE;
                    if (tick_reg && resched && found)
                    begin
                        res_task_next = tail_idx;
                        res_sw_next   = (tail_idx != cur_reg);
                        res_cnt_next  = tail_wave.best_cnt;
                        res_pri_next  = tail_wave.best_pri;
                        cur_next      = tail_idx;
                    end
                    else if (need_refill && (state_reg == S_SCAN1))
                    begin
                        launch_next = 1'b1;
                        state_next  = S_SCAN2;
                    end
                    else if (need_refill)
                    begin
                        res_nr_next = 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            launch_reg <= 1'b0;
            cur_reg    <= '0;
            tick_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
            cur_reg    <= cur_next;
            tick_reg   <= tick_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_task_reg <= res_task_next;
        res_sw_reg   <= res_sw_next;
        res_rf_reg   <= res_rf_next;
        res_nr_reg   <= res_nr_next;
        res_cnt_reg  <= res_cnt_next;
        res_pri_reg  <= res_pri_next;
    end

    // Hand the settled result to the output register once it is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if ((state_reg == S_DONE) && out_free)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && out_free)
        begin
            out_task_reg <= TASK_W'(res_task_reg);
            out_sw_reg   <= res_sw_reg;
            out_rf_reg   <= res_rf_reg;
            out_nr_reg   <= res_nr_reg;
            out_cnt_reg  <= res_cnt_reg;
            out_pri_reg  <= res_pri_reg;
        end
    end

    assign result_valid  = out_valid_reg;
    assign next_task     = out_task_reg;
    assign switched      = out_sw_reg;
    assign refilled      = out_rf_reg;
    assign none_ready    = out_nr_reg;
    assign next_counter  = out_cnt_reg;
    assign next_priority = out_pri_reg;

    // A failed search only ever follows a refill
    `TPS_ASSERT_NOW(a_none_after_refill, out_valid_reg && out_nr_reg, out_rf_reg)
    // A switch and a failed search never come together
    `TPS_ASSERT_NOW(a_switch_not_none, out_valid_reg && out_sw_reg, !out_nr_reg)
    // An accepted item always launches the first scan
    `TPS_ASSERT_NEXT(a_accept_launch, accept, launch_reg && (state_reg == S_SCAN1))
    // The wavefront only returns while a scan is pending
    `TPS_ASSERT_NOW(a_tail_in_scan, tail_go, (state_reg == S_SCAN1) || (state_reg == S_SCAN2))

endmodule

### sv/timeslice_priority_scheduler.sv
// Top level of the timeslice priority scheduler: sequencer and chain of task cells.
`timescale 1ns / 1ps

// Usage:
//   Item channel (item_valid / item_stall): mode 1 loads one task entry
//   (counter, priority, runnable, present) at task_index; mode 0 is a timer
//   tick that ages the running task and reschedules when its slice runs out or the idle task 0 runs.
//   Result channel (result_valid / result_stall): one result per item with
//   the running task, its counter and priority, and the switched, refilled
//   and none_ready flags.
//   A load or a tick without refill makes one scan of the chain; a tick that
//   refills makes a second scan after the refill command.
//   The block takes one item at a time and accepts the next one once the
//   result has landed in the output register. Each scan is a search
//   wavefront that walks the chain of NUM_TASKS cells one cell per cycle.
//   Reset clears the whole task table and makes the idle task 0 current;
//   no clearing pass is needed. While the receiver stalls, the result holds
//   in the output register; one more item may be processed behind it and
//   then waits until the output register frees up.
module timeslice_priority_scheduler
    import tps_pkg::*;
#(
    parameter int NUM_TASKS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic              mode,
    input  logic [TASK_W-1:0] task_index,
    input  logic [CNT_W-1:0]  load_counter,
    input  logic [PRI_W-1:0]  load_priority,
    input  logic              load_runnable,
    input  logic              load_present,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [TASK_W-1:0] next_task,
    output logic              switched,
    output logic              refilled,
    output logic              none_ready,
    output logic [CNT_W-1:0]  next_counter,
    output logic [PRI_W-1:0]  next_priority
);

    localparam int IDX_W = $clog2(NUM_TASKS);

    cell_cmd_t        cmd;
    logic [IDX_W-1:0] cmd_idx;
    logic [IDX_W-1:0] cur_idx;

    // Link k feeds cell k-1; link NUM_TASKS is the head, link 0 the tail
    logic             link_go   [NUM_TASKS+1];
    wave_t            link_wave [NUM_TASKS+1];
    logic [IDX_W-1:0] link_idx  [NUM_TASKS+1];

    tps_ctrl #(
        .NUM_TASKS (NUM_TASKS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .mode          (mode),
        .task_index    (task_index),
        .load_counter  (load_counter),
        .load_priority (load_priority),
        .load_runnable (load_runnable),
        .load_present  (load_present),
        .cmd           (cmd),
        .cmd_idx       (cmd_idx),
        .cur_idx       (cur_idx),
        .head_go       (link_go[NUM_TASKS]),
        .head_wave     (link_wave[NUM_TASKS]),
        .head_idx      (link_idx[NUM_TASKS]),
        .tail_go       (link_go[0]),
        .tail_wave     (link_wave[0]),
        .tail_idx      (link_idx[0]),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .next_task     (next_task),
        .switched      (switched),
        .refilled      (refilled),
        .none_ready    (none_ready),
        .next_counter  (next_counter),
        .next_priority (next_priority)
    );

    // Build the chain from the highest task down to the idle task
    for (genvar i = 0; i < NUM_TASKS; i++)
    begin : g_cell
        tps_cell #(
            .NUM_TASKS (NUM_TASKS),
            .CELL_IDX  (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cmd),
            .cmd_idx      (cmd_idx),
            .cur_idx      (cur_idx),
            .go_in        (link_go[i+1]),
            .wave_in      (link_wave[i+1]),
            .wave_in_idx  (link_idx[i+1]),
            .go_out       (link_go[i]),
            .wave_out     (link_wave[i]),
            .wave_out_idx (link_idx[i])
        );
    end

endmodule
